// ----- design/lpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared constants for the lidar point covariance unit.
// ----------------------------------------------------------------------------
package lpc_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int BEAR_SHIFT      = 8 + 2 * COORD_FRAC_BITS;

    localparam int COORD_W  = 32;
    localparam int COV_W    = 48;
    localparam int RSTD_W   = 16;
    localparam int RV_W     = 2 * RSTD_W;
    localparam int BVAR_W   = 40;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int BPART_W  = 63;
    localparam int LANES    = 6;
    localparam int DIV_BITS = RV_W;

    localparam logic [RV_W-1:0]    RV_RESET   = RV_W'(1311 * 1311);
    localparam logic [BVAR_W-1:0]  BVAR_RESET = BVAR_W'(7532000);
    localparam logic [BPART_W-1:0] MAG_CAP    = BPART_W'(64'd1 << 62);

    localparam logic signed [64:0] OUT_MAX = 65'sd140737488355327;
    localparam logic signed [64:0] OUT_MIN = -65'sd140737488355328;

    localparam logic REG_RANGE_STD   = 1'b0;
    localparam logic REG_BEARING_VAR = 1'b1;

endpackage

// ----- design/lidar_point_covariance_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_point_covariance_unit
// Range/bearing covariance of one lidar point, six unique entries, saturated.
// ----------------------------------------------------------------------------
// pipeline: 5 arithmetic stages, 32 stages of a one-bit-per-stage restoring
// divider, one output register
// throughput: one point per cycle; the whole pipe holds while the output
// beat is not taken
// reset: valid bits cleared, registers back to range_std 1311, bearing_var 7532000
module lidar_point_covariance_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [39:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // point_x, point_y, point_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [287:0] m_axis_tdata,   // cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz
    output logic         m_axis_tuser    // zero_range
);

    localparam int L  = lpc_pkg::LANES;
    localparam int DB = lpc_pkg::DIV_BITS;

    logic [lpc_pkg::RV_W-1:0]   rv_reg;
    logic [lpc_pkg::BVAR_W-1:0] bv_reg;
    logic                       adv;

    // stage 1
    logic        s1_vld_reg;
    logic [31:0] s1_mag_reg [0:2];
    logic        s1_neg_reg [0:2];
    // stage 2
    logic        s2_vld_reg;
    logic [63:0] s2_sq_reg  [0:2];
    logic [63:0] s2_prd_reg [0:2];
    logic        s2_neg_reg [0:2];
    // stage 3
    logic        s3_vld_reg;
    logic [63:0] s3_r2_reg;
    logic [63:0] s3_num_reg  [0:L-1];
    logic [63:0] s3_bmag_reg [0:L-1];
    logic        s3_flip_reg [0:L-1];
    // stage 4
    logic        s4_vld_reg;
    logic [63:0] s4_r2_reg;
    logic [63:0] s4_plo_reg [0:L-1];
    logic [63:0] s4_phi_reg [0:L-1];
    logic [71:0] s4_blo_reg [0:L-1];
    logic [71:0] s4_bhi_reg [0:L-1];
    logic        s4_flip_reg [0:L-1];
    // divider stages, index 0 is loaded from stage 4
    logic        dv_vld_reg  [0:DB];
    logic [63:0] dv_den_reg  [0:DB];
    logic [63:0] dv_rem_reg  [0:DB][0:L-1];
    logic [31:0] dv_low_reg  [0:DB][0:L-1];
    logic [31:0] dv_q_reg    [0:DB][0:L-1];
    logic [62:0] dv_bp_reg   [0:DB][0:L-1];
    logic        dv_flip_reg [0:DB][0:L-1];
    logic [63:0] dv_rem_next [1:DB][0:L-1];
    logic [31:0] dv_q_next   [1:DB][0:L-1];
    // output
    logic         out_vld_reg;
    logic [287:0] out_data_reg;
    logic         out_zero_reg;
    logic [287:0] out_data_next;

    logic [95:0]  s5_num  [0:L-1];
    logic [103:0] s5_bsum [0:L-1];
    logic [103:0] s5_bsh  [0:L-1];
    logic [62:0]  s5_bp   [0:L-1];

    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_zero_reg;

    // configuration, rv kept squared
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= lpc_pkg::RV_RESET;
            bv_reg <= lpc_pkg::BVAR_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lpc_pkg::REG_RANGE_STD:   rv_reg <= cfg_data[15:0] * cfg_data[15:0];
                lpc_pkg::REG_BEARING_VAR: bv_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k <= DB; k++)
            begin
                dv_vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s1_vld_reg    <= s_axis_tvalid;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            s4_vld_reg    <= s3_vld_reg;
            dv_vld_reg[0] <= s4_vld_reg;
            for (int k = 1; k <= DB; k++)
            begin
                dv_vld_reg[k] <= dv_vld_reg[k-1];
            end
            out_vld_reg <= dv_vld_reg[DB];
        end
    end

    // stage 4 combine and bearing scale
    always_comb
    begin
        for (int n = 0; n < L; n++)
        begin
            s5_num[n]  = {32'd0, s4_plo_reg[n]} + {s4_phi_reg[n], 32'd0};
            s5_bsum[n] = {32'd0, s4_blo_reg[n]} + {s4_bhi_reg[n], 32'd0};
            s5_bsh[n]  = s5_bsum[n] >> lpc_pkg::BEAR_SHIFT;
            s5_bp[n]   = (s5_bsh[n] > {41'd0, lpc_pkg::MAG_CAP}) ? lpc_pkg::MAG_CAP
                                                                 : s5_bsh[n][62:0];
        end
    end

    // one quotient bit per divider stage
    always_comb
    begin
        logic [64:0] sh;
        for (int k = 1; k <= DB; k++)
        begin
            for (int n = 0; n < L; n++)
            begin
                sh = {dv_rem_reg[k-1][n], dv_low_reg[k-1][n][31]};
                if (sh >= {1'b0, dv_den_reg[k-1]})
                begin
                    sh                = sh - {1'b0, dv_den_reg[k-1]};
                    dv_q_next[k][n]   = {dv_q_reg[k-1][n][30:0], 1'b1};
                end
                else
                begin
                    dv_q_next[k][n]   = {dv_q_reg[k-1][n][30:0], 1'b0};
                end
                dv_rem_next[k][n] = sh[63:0];
            end
        end
    end

    // final sum, sign and saturation
    always_comb
    begin
        logic signed [64:0] e;
        logic signed [64:0] rp;
        logic signed [64:0] bp;
        logic signed [64:0] s;
        for (int n = 0; n < L; n++)
        begin
            rp = {33'd0, dv_q_reg[DB][n]};
            bp = {2'd0, dv_bp_reg[DB][n]};
            if (n == 0 || n == 3 || n == 5)
            begin
                e = rp + bp;
            end
            else if (dv_flip_reg[DB][n])
            begin
                e = bp - rp;
            end
            else
            begin
                e = rp - bp;
            end
            if (e > lpc_pkg::OUT_MAX)
            begin
                s = lpc_pkg::OUT_MAX;
            end
            else if (e < lpc_pkg::OUT_MIN)
            begin
                s = lpc_pkg::OUT_MIN;
            end
            else
            begin
                s = e;
            end
            // origin point gives all zeros
            out_data_next[n*48 +: 48] = (dv_den_reg[DB] == 64'd0) ? 48'd0 : s[47:0];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_neg_reg[i] <= s_axis_tdata[i*32 + 31];
                s1_mag_reg[i] <= s_axis_tdata[i*32 + 31] ? (~s_axis_tdata[i*32 +: 32] + 32'd1)
                                                         : s_axis_tdata[i*32 +: 32];
                s2_sq_reg[i]  <= s1_mag_reg[i] * s1_mag_reg[i];
                s2_neg_reg[i] <= s1_neg_reg[i];
            end
            s2_prd_reg[0] <= s1_mag_reg[0] * s1_mag_reg[1];
            s2_prd_reg[1] <= s1_mag_reg[0] * s1_mag_reg[2];
            s2_prd_reg[2] <= s1_mag_reg[1] * s1_mag_reg[2];

            // lanes: xx, xy, xz, yy, yz, zz
            s3_r2_reg      <= s2_sq_reg[0] + s2_sq_reg[1] + s2_sq_reg[2];
            s3_num_reg[0]  <= s2_sq_reg[0];
            s3_num_reg[1]  <= s2_prd_reg[0];
            s3_num_reg[2]  <= s2_prd_reg[1];
            s3_num_reg[3]  <= s2_sq_reg[1];
            s3_num_reg[4]  <= s2_prd_reg[2];
            s3_num_reg[5]  <= s2_sq_reg[2];
            s3_bmag_reg[0] <= s2_sq_reg[1] + s2_sq_reg[2];
            s3_bmag_reg[1] <= s2_prd_reg[0];
            s3_bmag_reg[2] <= s2_prd_reg[1];
            s3_bmag_reg[3] <= s2_sq_reg[0] + s2_sq_reg[2];
            s3_bmag_reg[4] <= s2_prd_reg[2];
            s3_bmag_reg[5] <= s2_sq_reg[0] + s2_sq_reg[1];
            s3_flip_reg[0] <= 1'b0;
            s3_flip_reg[1] <= s2_neg_reg[0] ^ s2_neg_reg[1];
            s3_flip_reg[2] <= s2_neg_reg[0] ^ s2_neg_reg[2];
            s3_flip_reg[3] <= 1'b0;
            s3_flip_reg[4] <= s2_neg_reg[1] ^ s2_neg_reg[2];
            s3_flip_reg[5] <= 1'b0;

            s4_r2_reg <= s3_r2_reg;
            for (int n = 0; n < L; n++)
            begin
                s4_plo_reg[n]  <= rv_reg * s3_num_reg[n][31:0];
                s4_phi_reg[n]  <= rv_reg * s3_num_reg[n][63:32];
                s4_blo_reg[n]  <= bv_reg * s3_bmag_reg[n][31:0];
                s4_bhi_reg[n]  <= bv_reg * s3_bmag_reg[n][63:32];
                s4_flip_reg[n] <= s3_flip_reg[n];

                // quotient fits 32 bits, so the top 64 numerator bits start as remainder
                dv_rem_reg[0][n]  <= s5_num[n][95:32];
                dv_low_reg[0][n]  <= s5_num[n][31:0];
                dv_q_reg[0][n]    <= 32'd0;
                dv_bp_reg[0][n]   <= s5_bp[n];
                dv_flip_reg[0][n] <= s4_flip_reg[n];
            end
            dv_den_reg[0] <= s4_r2_reg;

            for (int k = 1; k <= DB; k++)
            begin
                dv_den_reg[k] <= dv_den_reg[k-1];
                for (int n = 0; n < L; n++)
                begin
                    dv_rem_reg[k][n]  <= dv_rem_next[k][n];
                    dv_low_reg[k][n]  <= {dv_low_reg[k-1][n][30:0], 1'b0};
                    dv_q_reg[k][n]    <= dv_q_next[k][n];
                    dv_bp_reg[k][n]   <= dv_bp_reg[k-1][n];
                    dv_flip_reg[k][n] <= dv_flip_reg[k-1][n];
                end
            end

            out_data_reg <= out_data_next;
            out_zero_reg <= (dv_den_reg[DB] == 64'd0);
        end
    end

endmodule
